FILE: rtl/core/utd_pkg.sv
// Shared widths, byte-range constants and stage types for the UTF-8 decoder.
package utd_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int SEQ_W  = 3;
    localparam int REM_W  = 2;

    // Lead byte ranges that open multi-byte sequences.
    localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD2_MAX = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_MAX = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_MAX = 8'hF4;

    // Sequence lengths in bytes.
    localparam logic [SEQ_W-1:0] SEQ_LEN1 = 3'd1;
    localparam logic [SEQ_W-1:0] SEQ_LEN2 = 3'd2;
    localparam logic [SEQ_W-1:0] SEQ_LEN3 = 3'd3;
    localparam logic [SEQ_W-1:0] SEQ_LEN4 = 3'd4;

    // Beat held in the input register.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] in_byte;
    } utd_byte_t;

    // Decoded result handed to the output register.
    typedef struct packed {
        logic             valid;
        logic [CP_W-1:0]  code_point;
        logic [SEQ_W-1:0] seq_bytes;
    } utd_result_t;

endpackage

FILE: rtl/core/utd_stream_ifs.sv
// Valid/ready stream interfaces for the byte input and the code point output.
interface utd_byte_if
    import utd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface utd_point_if
    import utd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CP_W-1:0]  code_point;
    logic [SEQ_W-1:0] seq_bytes;

    modport source (output valid, output code_point, output seq_bytes, input ready);
    modport sink   (input valid, input code_point, input seq_bytes, output ready);
endinterface

FILE: rtl/core/utd_in_stage.sv
// Input register: captures one byte beat and holds it until the decoder takes it.
module utd_in_stage
    import utd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [BYTE_W-1:0] in_byte,
    output logic              in_ready,
    input  logic              consume,
    output utd_byte_t         held
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    // The register can take a new beat when empty or when its beat leaves now.
    assign in_ready = !valid_reg || consume;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
        end
    end

    assign held.valid   = valid_reg;
    assign held.in_byte = byte_reg;

endmodule

FILE: rtl/core/utd_decode.sv
// Sequence state and decode logic between the input and output registers.
module utd_decode
    import utd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  utd_byte_t   held,
    input  logic        out_ready,
    output logic        consume,
    output utd_result_t result
);

    logic [REM_W-1:0] remaining_reg;
    logic [REM_W-1:0] remaining_next;
    logic [SEQ_W-1:0] seq_total_reg;
    logic [SEQ_W-1:0] seq_total_next;
    logic [CP_W-1:0]  partial_reg;
    logic [CP_W-1:0]  partial_next;
    logic             emit;
    logic [CP_W-1:0]  emit_value;
    logic [SEQ_W-1:0] emit_len;
    logic [CP_W-1:0]  shifted;
    logic [REM_W-1:0] rem_dec;
    logic [BYTE_W-1:0] b;

    assign b       = held.in_byte;
    assign shifted = {partial_reg[CP_W-7:0], b[5:0]};
    assign rem_dec = remaining_reg - 2'd1;

    always_comb
    begin
        remaining_next = remaining_reg;
        seq_total_next = seq_total_reg;
        partial_next   = partial_reg;
        emit           = 1'b0;
        emit_value     = shifted;
        emit_len       = seq_total_reg;
        if (remaining_reg == '0)
        begin
            // Idle: plain bytes pass through, lead bytes open a sequence,
            // and bytes above the last lead are dropped.
            if (b < LEAD2_MIN)
            begin
                emit       = 1'b1;
                emit_value = {{(CP_W-BYTE_W){1'b0}}, b};
                emit_len   = SEQ_LEN1;
            end
            else if (b inside {[LEAD2_MIN:LEAD2_MAX]})
            begin
                partial_next   = {{(CP_W-5){1'b0}}, b[4:0]};
                remaining_next = 2'd1;
                seq_total_next = SEQ_LEN2;
            end
            else if (b inside {[LEAD3_MIN:LEAD3_MAX]})
            begin
                partial_next   = {{(CP_W-4){1'b0}}, b[3:0]};
                remaining_next = 2'd2;
                seq_total_next = SEQ_LEN3;
            end
            else if (b inside {[LEAD4_MIN:LEAD4_MAX]})
            begin
                partial_next   = {{(CP_W-3){1'b0}}, b[2:0]};
                remaining_next = 2'd3;
                seq_total_next = SEQ_LEN4;
            end
        end
        else
        begin
            // Any byte inside an open sequence counts as a continuation.
            remaining_next = rem_dec;
            partial_next   = shifted;
            if (rem_dec == '0)
            begin
                emit           = 1'b1;
                partial_next   = '0;
                seq_total_next = '0;
            end
        end
    end

    // A beat that yields a result leaves only when the output register can take it.
    assign consume = held.valid && (!emit || out_ready);

    assign result.valid      = held.valid && emit;
    assign result.code_point = emit_value;
    assign result.seq_bytes  = emit_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            seq_total_reg <= '0;
            partial_reg   <= '0;
        end
        else if (consume)
        begin
            remaining_reg <= remaining_next;
            seq_total_reg <= seq_total_next;
            partial_reg   <= partial_next;
        end
    end

endmodule

FILE: rtl/core/utd_out_stage.sv
// Output register: holds one decoded code point until the receiver takes it.
module utd_out_stage
    import utd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  utd_result_t      result,
    output logic             out_ready,
    output logic             dst_valid,
    output logic [CP_W-1:0]  dst_code_point,
    output logic [SEQ_W-1:0] dst_seq_bytes,
    input  logic             dst_ready
);

    logic             valid_reg;
    logic             valid_next;
    logic [CP_W-1:0]  cp_reg;
    logic [SEQ_W-1:0] len_reg;

    assign out_ready = !valid_reg || dst_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_ready)
        begin
            valid_next = result.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && result.valid)
        begin
            cp_reg  <= result.code_point;
            len_reg <= result.seq_bytes;
        end
    end

    assign dst_valid      = valid_reg;
    assign dst_code_point = cp_reg;
    assign dst_seq_bytes  = len_reg;

endmodule

FILE: rtl/core/utf8_to_code_point_decoder.sv
// Top level of the lenient UTF-8 to code point decoder.
//
// The block takes one raw byte per beat on the bytes channel and gives one
// decoded code point with its byte count on the points channel. Both channels
// use valid/ready; a beat moves at a rising edge where both are high.
// A byte below C2 while no sequence is open comes out at once as a one-byte
// code point. Lead bytes C2-DF, E0-EF and F0-F4 open sequences of two, three
// or four bytes; every byte inside an open sequence is taken as a
// continuation and adds its low six bits, and the full code point comes out
// with the final byte. Bytes F5-FF outside a sequence are dropped.
// An accepted byte waits in the input register, and its code point then in
// the output register, before it shows on points. The block takes one byte
// per cycle while the receiver keeps up, updating the sequence state per byte.
// Reset clears both registers and returns the decoder to the idle state,
// discarding any partial sequence. When the receiver stalls, the output
// register holds its code point; the decoder keeps taking bytes that give no
// result, and stalls the byte channel only when a second code point is due.
module utf8_to_code_point_decoder
    import utd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    utd_byte_if.sink    bytes,
    utd_point_if.source points
);

    utd_byte_t   held;
    utd_result_t result;
    logic        consume;
    logic        out_ready;
    logic        in_ready;

    // Input register.
    utd_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (bytes.valid),
        .in_byte  (bytes.in_byte),
        .in_ready (in_ready),
        .consume  (consume),
        .held     (held)
    );

    assign bytes.ready = in_ready;

    // Sequence tracking and code point assembly.
    utd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .held      (held),
        .out_ready (out_ready),
        .consume   (consume),
        .result    (result)
    );

    // Output register toward the receiver.
    utd_out_stage u_out_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .result         (result),
        .out_ready      (out_ready),
        .dst_valid      (points.valid),
        .dst_code_point (points.code_point),
        .dst_seq_bytes  (points.seq_bytes),
        .dst_ready      (points.ready)
    );

endmodule

FILE: bench/utf8_to_code_point_decoder_tb.sv
// Self-checking bench for the UTF-8 decoder: stream stimulus and scoreboard.
`timescale 1ns / 1ps

module utf8_to_code_point_decoder_tb
    import utd_pkg::*;
();

    // Cycle budget for the whole run. It leaves a wide margin for a plan of
    // near 1800 bytes.
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BYTES = 1800;
    // Percentage of cycles in which a side idles outside the steady stretch.
    localparam int IDLE_PCT = 38;
    // Range of accepted bytes during which neither side idles.
    localparam int STEADY_FIRST = 700;
    localparam int STEADY_LAST = 1000;
    // Cap on printed mismatch lines; the count itself is never capped.
    localparam int PRINT_CAP = 100;

    // One decoded code point as the block should give it.
    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [SEQ_W-1:0] seq_bytes;
    } decoded_point_t;

    // Scoreboard: tracks the decoder state byte by byte and keeps the
    // code points that are still due on the points channel.
    class point_scoreboard;
        logic [REM_W-1:0] bytes_left;
        logic [SEQ_W-1:0] open_len;
        logic [CP_W-1:0]  gathered;
        decoded_point_t   due_points[$];
        int               mismatches;
        int               bytes_taken;

        function new();
            bytes_left = '0;
            open_len = '0;
            gathered = '0;
            mismatches = 0;
            bytes_taken = 0;
        endfunction

        task report_mismatch(string msg);
            if (mismatches < PRINT_CAP)
                $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        function int pending();
            return due_points.size();
        endfunction

        // Advance the decoder state by one accepted byte.
        function void note_byte(logic [BYTE_W-1:0] b);
            decoded_point_t pt;
            bytes_taken++;
            if (bytes_left == '0)
            begin
                if (b < LEAD2_MIN)
                begin
                    pt.code_point = CP_W'(b);
                    pt.seq_bytes = SEQ_LEN1;
                    due_points = {due_points, pt};
                end
                else if (b <= LEAD2_MAX)
                begin
                    gathered = CP_W'(b[4:0]);
                    bytes_left = 2'd1;
                    open_len = SEQ_LEN2;
                end
                else if (b <= LEAD3_MAX)
                begin
                    gathered = CP_W'(b[3:0]);
                    bytes_left = 2'd2;
                    open_len = SEQ_LEN3;
                end
                else if (b <= LEAD4_MAX)
                begin
                    gathered = CP_W'(b[2:0]);
                    bytes_left = 2'd3;
                    open_len = SEQ_LEN4;
                end
                // Bytes above the last lead are dropped without a trace.
            end
            else
            begin
                // Any byte inside an open sequence counts as a continuation.
                gathered = {gathered[CP_W-7:0], b[5:0]};
                bytes_left = bytes_left - 2'd1;
                if (bytes_left == '0)
                begin
                    pt.code_point = gathered;
                    pt.seq_bytes = open_len;
                    due_points = {due_points, pt};
                    gathered = '0;
                    open_len = '0;
                end
            end
        endfunction

        // Compare one accepted result beat with the oldest code point due.
        task check_point(logic [CP_W-1:0] cp, logic [SEQ_W-1:0] nb);
            decoded_point_t want;
            if (due_points.size() == 0)
            begin
                report_mismatch($sformatf("unexpected code point %h (%0d bytes)", cp, nb));
            end
            else
            begin
                want = due_points.pop_front();
                if (cp !== want.code_point)
                    report_mismatch($sformatf("code_point %h, wanted %h",
                                              cp, want.code_point));
                if (nb !== want.seq_bytes)
                    report_mismatch($sformatf("seq_bytes %0d, wanted %0d",
                                              nb, want.seq_bytes));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count = 0;

    utd_byte_if  bytes_ch();
    utd_point_if points_ch();

    utf8_to_code_point_decoder i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (bytes_ch),
        .points (points_ch)
    );

    point_scoreboard        sb = new();
    // Bytes waiting to be offered on the bytes channel, in order.
    logic [BYTE_W-1:0]      byte_plan[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Append one sequence to the plan. A well-formed sequence has a lead
    // from the proper range and continuations 80-BF; a broken one keeps the
    // lead but fills the rest with any byte at all, so ASCII and lead bytes
    // land inside open sequences.
    task add_sequence(int len, bit broken);
        logic [BYTE_W-1:0] lead;
        case (len)
            1: lead = BYTE_W'($urandom_range(8'hC1, 8'h00));
            2: lead = BYTE_W'($urandom_range(LEAD2_MAX, LEAD2_MIN));
            3: lead = BYTE_W'($urandom_range(LEAD3_MAX, LEAD3_MIN));
            default: lead = BYTE_W'($urandom_range(LEAD4_MAX, LEAD4_MIN));
        endcase
        byte_plan = {byte_plan, lead};
        for (int i = 1; i < len; i++)
        begin
            if (broken)
                byte_plan = {byte_plan, BYTE_W'($urandom_range(255))};
            else
                byte_plan = {byte_plan, BYTE_W'($urandom_range(8'hBF, 8'h80))};
        end
    endtask

    task build_plan();
        int pick;
        // Directed part: single-byte extremes, stray continuations, the two
        // single bytes just below the first lead, dropped bytes, the lowest lead of
        // each length with 80 continuations, F4 with FF bytes, and malformed continuations.
        byte_plan = '{8'h00, 8'h7F, 8'h80, 8'hC0, 8'hC1, 8'hF5, 8'hFF,
                      8'hC2, 8'h80,
                      8'hE0, 8'h80, 8'h80,
                      8'hF0, 8'h80, 8'h80, 8'h80,
                      8'hF4, 8'hFF, 8'hFF, 8'hFF,
                      8'hC3, 8'h41,
                      8'hE2, 8'hF5, 8'hC2};
        // Random part: mostly well-formed sequences, the rest noise bytes and
        // sequences with arbitrary continuation bytes.
        while (byte_plan.size() < RANDOM_BYTES + 25)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                add_sequence($urandom_range(4, 1), 1'b0);
            else if (pick < 85)
                byte_plan = {byte_plan, BYTE_W'($urandom_range(255))};
            else
                add_sequence($urandom_range(4, 2), 1'b1);
        end
    endtask

    // Neither side idles while the accepted byte count is in this window.
    function bit steady_stretch();
        return sb.bytes_taken >= STEADY_FIRST && sb.bytes_taken < STEADY_LAST;
    endfunction

    // Both channels are sampled and driven at the same rising edge. The
    // block updates its outputs with nonblocking assignments, so the values
    // read here are those of the cycle that just ended, and the new values
    // driven here take effect after every process has read the old ones.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            bytes_ch.valid <= 1'b0;
            points_ch.ready <= 1'b0;
        end
        else
        begin
            if (bytes_ch.valid && bytes_ch.ready)
                sb.note_byte(bytes_ch.in_byte);
            if (points_ch.valid && points_ch.ready)
                sb.check_point(points_ch.code_point, points_ch.seq_bytes);

            // A beat that is offered stays put until it is taken; a new
            // byte, or an idle cycle, follows only once the channel is free.
            if (!bytes_ch.valid || bytes_ch.ready)
            begin
                if (byte_plan.size() != 0 &&
                    (steady_stretch() || $urandom_range(99) >= IDLE_PCT))
                begin
                    bytes_ch.valid <= 1'b1;
                    bytes_ch.in_byte <= byte_plan.pop_front();
                end
                else
                begin
                    bytes_ch.valid <= 1'b0;
                end
            end

            points_ch.ready <= steady_stretch() || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Guard against a hang: a stuck handshake or a missing code point ends
    // the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        build_plan();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every planned byte has been taken by the block.
        while (byte_plan.size() != 0 || bytes_ch.valid) @(posedge clk);
        // Then until every due code point has come out.
        while (sb.pending() != 0) @(posedge clk);
        // The block has two register stages; a further wait catches any stray
        // beat that follows the last expected one.
        repeat (20) @(posedge clk);

        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/utd_pkg.sv
rtl/core/utd_stream_ifs.sv
rtl/core/utd_in_stage.sv
rtl/core/utd_decode.sv
rtl/core/utd_out_stage.sv
rtl/core/utf8_to_code_point_decoder.sv
bench/utf8_to_code_point_decoder_tb.sv
